[design/ascii_can_frame_encoder_unit_assert.svh]
// Assertion helpers for the ASCII CAN frame encoder.
`ifndef ASCII_CAN_FRAME_ENCODER_UNIT_ASSERT_SVH
`define ASCII_CAN_FRAME_ENCODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define ACFE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("acfe: same-cycle check failed");
`define ACFE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("acfe: next-cycle check failed");
`else
`define ACFE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ACFE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

[design/acfe_pkg.sv]
package acfe_pkg;

   localparam int CMD_DEPTH_DEFAULT = 4;

   localparam logic [7:0] CHAR_COLON = 8'h3A;  // ':'
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;  // ';'
   localparam logic [7:0] CHAR_S     = 8'h53;  // 'S'
   localparam logic [7:0] CHAR_Y     = 8'h59;  // 'Y'
   localparam logic [7:0] CHAR_N     = 8'h4E;  // 'N'
   localparam logic [7:0] HDR_BASE   = 8'h80;
   localparam logic [7:0] LEN_MAX    = 8'hFF;

   // configuration register indexes
   localparam logic CSR_NODE_CAN_ID   = 1'b0;
   localparam logic CSR_ETHERNET_MODE = 1'b1;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       frame_start;
      logic [1:0] priority_req;
      logic       message_end;
   } cmd_type;

   typedef struct packed {
      logic [6:0] node_can_id;
      logic       ethernet_mode;
   } cfg_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       run_last;
      logic       frame_done;
      logic [7:0] frame_length;
   } rsp_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = 8'h30 + {4'd0, nib};
      end else begin
         ch = 8'h37 + {4'd0, nib};
      end
      return ch;
   endfunction

endpackage

[design/ascii_can_frame_encoder_unit.sv]
// Encodes CAN messages, given one byte per request, into GridConnect ASCII
// characters, one result per character. An opening request (frame_start)
// yields nine characters (':', 'S' or 'Y', four header hex digits, 'N', two
// opcode digits), a data request yields two hex digits, and message_end adds
// a closing ';'. The back sequencer emits one character per clock while its
// two-entry result queue has room, and requests are taken every cycle until
// the CMD_DEPTH-entry command queue fills; an item passes through that queue,
// the current-item register and the result queue. Configuration is written
// through csr_* by the user only while the block is idle; the block does not enforce it.
module ascii_can_frame_encoder_unit import acfe_pkg::*; #(
   parameter int CMD_DEPTH = CMD_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_byte_value,
   input  logic       req_frame_start,
   input  logic [1:0] req_priority_req,
   input  logic       req_message_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_run_last,
   output logic       rsp_frame_done,
   output logic [7:0] rsp_frame_length,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [6:0] csr_write_data
);

   cfg_type cfg_ff;
   cmd_type cmd_head;
   logic    cmd_empty, cmd_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_NODE_CAN_ID:   cfg_ff.node_can_id   <= csr_write_data;
            CSR_ETHERNET_MODE: cfg_ff.ethernet_mode <= csr_write_data[0];
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   acfe_front #(
      .CMD_DEPTH (CMD_DEPTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_byte_value   (req_byte_value),
      .req_frame_start  (req_frame_start),
      .req_priority_req (req_priority_req),
      .req_message_end  (req_message_end),
      .cmd_pop          (cmd_pop),
      .cmd_empty        (cmd_empty),
      .cmd_head         (cmd_head)
   );

   acfe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd_empty        (cmd_empty),
      .cmd_head         (cmd_head),
      .cmd_pop          (cmd_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_out_char     (rsp_out_char),
      .rsp_run_last     (rsp_run_last),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_frame_length (rsp_frame_length)
   );

endmodule

[design/acfe_front.sv]
module acfe_front import acfe_pkg::*; #(
   parameter int CMD_DEPTH = CMD_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_byte_value,
   input  logic       req_frame_start,
   input  logic [1:0] req_priority_req,
   input  logic       req_message_end,
   input  logic       cmd_pop,
   output logic       cmd_empty,
   output cmd_type    cmd_head
);

   localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   cmd_type            cmd_mem [CMD_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push_ok, pop_ok;
   cmd_type            cmd_new;

   assign req_full  = (count_ff == CNT_W'(CMD_DEPTH));
   assign cmd_empty = (count_ff == '0);
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && !cmd_empty;
   assign cmd_head  = cmd_mem[rd_ptr_ff];

   // the priority only matters on an opening item
   always_comb begin
      cmd_new.byte_value   = req_byte_value;
      cmd_new.frame_start  = req_frame_start;
      cmd_new.priority_req = req_frame_start ? req_priority_req : 2'd0;
      cmd_new.message_end  = req_message_end;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         cmd_mem[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

[design/acfe_back.sv]
`include "ascii_can_frame_encoder_unit_assert.svh"

module acfe_back import acfe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       cmd_empty,
   input  cmd_type    cmd_head,
   output logic       cmd_pop,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_out_char,
   output logic       rsp_run_last,
   output logic       rsp_frame_done,
   output logic [7:0] rsp_frame_length
);

   typedef enum logic [3:0] {
      ST_COLON, ST_TYPE, ST_HI_HI, ST_HI_LO, ST_LO_HI, ST_LO_LO,
      ST_N, ST_OP_HI, ST_OP_LO, ST_SEMI
   } step_type;

   step_type   step_ff, step_next;
   logic       busy_ff;
   cmd_type    cur_ff;
   logic [7:0] count_ff;

   rsp_type    out_mem [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] out_cnt_ff;

   logic       emit, last_step, load, out_pop;
   logic [7:0] hdr_hi, hdr_lo, nib_src, count_base, count_new;
   rsp_type    rsp_new;

   assign hdr_hi = HDR_BASE + {1'b0, cur_ff.priority_req, 5'd0}
                 + {4'd0, cfg.node_can_id[6:3]};
   assign hdr_lo = {cfg.node_can_id[2:0], 5'd0};

   assign emit      = busy_ff && (out_cnt_ff != 2'd2);
   assign last_step = cur_ff.message_end ? (step_ff == ST_SEMI) : (step_ff == ST_OP_LO);
   assign load      = !busy_ff || (emit && last_step);
   assign cmd_pop   = load && !cmd_empty;

   // the colon opens a frame, so the count restarts there
   assign count_base = (step_ff == ST_COLON) ? 8'd0 : count_ff;
   assign count_new  = (count_base == LEN_MAX) ? LEN_MAX : count_base + 8'd1;

   always_comb begin
      case (step_ff)
         ST_HI_HI, ST_HI_LO: nib_src = hdr_hi;
         ST_LO_HI, ST_LO_LO: nib_src = hdr_lo;
         default:            nib_src = cur_ff.byte_value;
      endcase
   end

   always_comb begin
      case (step_ff)
         ST_COLON: rsp_new.out_char = CHAR_COLON;
         ST_TYPE:  rsp_new.out_char = cfg.ethernet_mode ? CHAR_Y : CHAR_S;
         ST_N:     rsp_new.out_char = CHAR_N;
         ST_SEMI:  rsp_new.out_char = CHAR_SEMI;
         ST_HI_HI, ST_LO_HI, ST_OP_HI: rsp_new.out_char = hex_char(nib_src[7:4]);
         default:  rsp_new.out_char = hex_char(nib_src[3:0]);
      endcase
      rsp_new.run_last     = last_step;
      rsp_new.frame_done   = (step_ff == ST_SEMI);
      rsp_new.frame_length = count_new;
   end

   always_comb begin
      case (step_ff)
         ST_COLON: step_next = ST_TYPE;
         ST_TYPE:  step_next = ST_HI_HI;
         ST_HI_HI: step_next = ST_HI_LO;
         ST_HI_LO: step_next = ST_LO_HI;
         ST_LO_HI: step_next = ST_LO_LO;
         ST_LO_LO: step_next = ST_N;
         ST_N:     step_next = ST_OP_HI;
         ST_OP_HI: step_next = ST_OP_LO;
         ST_OP_LO: step_next = ST_SEMI;
         default:  step_next = ST_SEMI;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         step_ff  <= ST_COLON;
         count_ff <= 8'd0;
      end else begin
         if (load) begin
            busy_ff <= !cmd_empty;
            cur_ff  <= cmd_head;
            step_ff <= cmd_head.frame_start ? ST_COLON : ST_OP_HI;
         end else if (emit) begin
            step_ff <= step_next;
         end
         if (emit) begin
            count_ff <= count_new;
         end
      end
   end

   // two-entry result queue
   assign out_pop          = rsp_pop && (out_cnt_ff != 2'd0);
   assign rsp_empty        = (out_cnt_ff == 2'd0);
   assign rsp_out_char     = out_mem[rd_ptr_ff].out_char;
   assign rsp_run_last     = out_mem[rd_ptr_ff].run_last;
   assign rsp_frame_done   = out_mem[rd_ptr_ff].frame_done;
   assign rsp_frame_length = out_mem[rd_ptr_ff].frame_length;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
         out_cnt_ff <= 2'd0;
      end else begin
         if (emit) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (out_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (emit && !out_pop) begin
            out_cnt_ff <= out_cnt_ff + 2'd1;
         end else if (out_pop && !emit) begin
            out_cnt_ff <= out_cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_mem[wr_ptr_ff] <= rsp_new;
      end
   end

   `ACFE_ASSERT_IMP(a_out_cnt_bound, clock, reset, 1'b1, out_cnt_ff != 2'd3)
   `ACFE_ASSERT_IMP(a_semi_needs_end, clock, reset, busy_ff && (step_ff == ST_SEMI), cur_ff.message_end)
   `ACFE_ASSERT_IMP(a_len_nonzero, clock, reset, emit, rsp_new.frame_length != 8'd0)
   `ACFE_ASSERT_NXT(a_emit_fills, clock, reset, emit && !out_pop, out_cnt_ff != 2'd0)

endmodule
